### hdl/utf8s_pkg.sv
// Package for the UTF-8 sanitizer stream block.
// Holds the burst and queue item types, sizes and the replacement character bytes.
// No dependencies.
package utf8s_pkg;

    // Largest number of output bytes that one input byte can cause.
    localparam int BURST_MAX = 12;
    localparam int BURST_CW  = $clog2(BURST_MAX + 1);
    localparam int BURST_IW  = $clog2(BURST_MAX);

    // Bytes of U+FFFD in UTF-8.
    localparam logic [7:0] REPL_0 = 8'hEF;
    localparam logic [7:0] REPL_1 = 8'hBF;
    localparam logic [7:0] REPL_2 = 8'hBD;

    // All output bytes caused by one accepted input byte.
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [BURST_CW-1:0]       count;
        logic                      fin;
    } burst_t;

    // One output item as it enters the output queue.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_end;
    } out_item_t;

    // Status of the burst serializer, used by the checks at the top level.
    typedef struct packed {
        logic                active;
        logic [BURST_IW-1:0] rd;
        logic [BURST_CW-1:0] count;
    } burst_stat_t;

    // Byte of the replacement character at a given position within it.
    function automatic logic [7:0] repl_byte(input logic [1:0] phase);
        logic [7:0] b;
        unique case (phase)
            2'd0:    b = REPL_0;
            2'd1:    b = REPL_1;
            default: b = REPL_2;
        endcase
        return b;
    endfunction

endpackage

### hdl/utf8s_decode.sv
// Decoder of the UTF-8 sanitizer: holds the partial sequence and builds the output burst.
// Depends on utf8s_pkg.
module utf8s_decode
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    output logic              load,
    output utf8s_pkg::burst_t burst,
    output logic [1:0]        held_count
);

    logic [2:0][7:0] held_reg;
    logic [2:0][7:0] held_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic [2:0]      need_reg;
    logic [2:0]      need_next;

    logic            cont;
    logic            lead_go;
    logic [2:0]      n_repl;
    logic [2:0]      n_mid;
    logic [1:0]      mid_src;
    logic [3:0]      rep_end;
    logic [1:0]      mid_idx;

    assign cont = (data_byte[7:6] == 2'b10);

    always_comb
    begin
        held_next  = held_reg;
        count_next = count_reg;
        need_next  = need_reg;
        n_repl     = 3'd0;
        n_mid      = 3'd0;
        mid_src    = 2'd0;
        lead_go    = 1'b0;

        if (count_reg != 2'd0)
        begin
            if (cont)
            begin
                if (({1'b0, count_reg} + 3'd1) >= need_reg)
                begin
                    // Sequence complete: release held bytes and this one.
                    n_mid      = {1'b0, count_reg} + 3'd1;
                    mid_src    = count_reg;
                    count_next = 2'd0;
                    need_next  = 3'd0;
                end
                else
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        if (count_reg == 2'(j))
                        begin
                            held_next[j] = data_byte;
                        end
                    end
                    count_next = count_reg + 2'd1;
                end
            end
            else
            begin
                // Broken sequence: every held byte becomes a replacement.
                n_repl     = {1'b0, count_reg};
                count_next = 2'd0;
                need_next  = 3'd0;
                lead_go    = 1'b1;
            end
        end
        else
        begin
            lead_go = 1'b1;
        end

        if (lead_go)
        begin
            priority if (data_byte[7] == 1'b0)
            begin
                n_mid = 3'd1;
            end
            else if (data_byte[7:5] == 3'b110)
            begin
                held_next[0] = data_byte;
                count_next   = 2'd1;
                need_next    = 3'd2;
            end
            else if (data_byte[7:4] == 4'b1110)
            begin
                held_next[0] = data_byte;
                count_next   = 2'd1;
                need_next    = 3'd3;
            end
            else if (data_byte[7:3] == 5'b11110)
            begin
                held_next[0] = data_byte;
                count_next   = 2'd1;
                need_next    = 3'd4;
            end
            else
            begin
                n_repl = n_repl + 3'd1;
            end
        end

        // End of text flushes whatever is still held.
        if (final_byte)
        begin
            n_repl     = n_repl + {1'b0, count_next};
            count_next = 2'd0;
            need_next  = 3'd0;
        end
    end

    // The burst is replacements first, then released bytes; a flush at end of text
    // only happens with no released bytes, so it joins the leading replacements.
    assign rep_end = ({1'b0, n_repl} << 1) + {1'b0, n_repl};

    always_comb
    begin
        mid_idx = 2'd0;
        for (int p = 0; p < utf8s_pkg::BURST_MAX; p++)
        begin
            mid_idx = 2'(4'(p) - rep_end);
            if (4'(p) < rep_end)
            begin
                burst.bytes[p] = utf8s_pkg::repl_byte(2'(p % 3));
            end
            else
            begin
                burst.bytes[p] = data_byte;
                for (int j = 0; j < 3; j++)
                begin
                    if ((mid_idx == 2'(j)) && (2'(j) < mid_src))
                    begin
                        burst.bytes[p] = held_reg[j];
                    end
                end
            end
        end
        burst.count = utf8s_pkg::BURST_CW'(rep_end + {1'b0, n_mid});
        burst.fin   = final_byte;
    end

    assign load        = accept && (burst.count != '0);
    assign held_count  = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            need_reg  <= 3'd0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            need_reg  <= need_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

### hdl/utf8s_burst.sv
// UTF-8 sanitizer burst register and serializer: one byte per cycle while space.
// Depends on utf8s_pkg.
module utf8s_burst
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  utf8s_pkg::burst_t      burst_in,
    input  logic                   space,
    output logic                   in_ready,
    output logic                   push,
    output utf8s_pkg::out_item_t   item,
    output utf8s_pkg::burst_stat_t stat
);

    utf8s_pkg::burst_t             burst_reg;
    logic                          active_reg;
    logic [utf8s_pkg::BURST_IW-1:0] rd_reg;
    logic                          last;

    assign last     = (utf8s_pkg::BURST_CW'(rd_reg)
                       == (burst_reg.count - utf8s_pkg::BURST_CW'(1)));
    assign push     = active_reg && space;
    assign in_ready = !active_reg || (last && space);

    assign item.out_byte = burst_reg.bytes[rd_reg];
    assign item.run_last = last;
    assign item.text_end = last && burst_reg.fin;

    assign stat.active = active_reg;
    assign stat.rd     = rd_reg;
    assign stat.count  = burst_reg.count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            rd_reg     <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            rd_reg     <= '0;
        end
        else if (push)
        begin
            if (last)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                rd_reg <= rd_reg + utf8s_pkg::BURST_IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst_in;
        end
    end

endmodule

### hdl/utf8s_outq.sv
// Two-entry output queue of the UTF-8 sanitizer; it parts the output handshake from the serializer.
// Depends on utf8s_pkg.
module utf8s_outq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  utf8s_pkg::out_item_t item,
    output logic                 space,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output utf8s_pkg::out_item_t head
);

    utf8s_pkg::out_item_t q_reg [2];
    logic                 wr_reg;
    logic                 rd_reg;
    logic [1:0]           cnt_reg;
    logic                 pop;

    assign space    = (cnt_reg != 2'd2);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign head     = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= item;
        end
    end

endmodule

### hdl/utf8_sanitize_stream.sv
// Top level of the UTF-8 sanitizer stream block.
// Depends on utf8s_pkg, utf8s_decode, utf8s_burst and utf8s_outq.
//
// Channel  Dir  Handshake           tdata        tlast       tuser
// s_*      in   s_tvalid/s_tready   data_byte    final_byte  -
// m_*      out  m_tvalid/m_tready   out_byte     run_last    text_end
//
// Each accepted byte is decoded in the cycle it is accepted and its whole output burst
// (0 to 12 bytes) is stored in the burst register when not empty. The serializer moves
// one burst byte per cycle into a two-entry output queue while the queue has space;
// a plain ASCII stream runs at one byte per cycle under the same condition.
// A new request is taken when the burst register is empty or its last byte moves on.
// Reset empties the held sequence, the burst register and the output queue.
// A stalled output fills the queue and then holds the burst, which in turn holds input.
module utf8_sanitize_stream
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // final_byte

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic [0:0] m_tuser    // [0] text_end
);

    logic                   accept;
    logic                   load;
    utf8s_pkg::burst_t      burst;
    logic [1:0]             held_count;
    logic                   space;
    logic                   push;
    utf8s_pkg::out_item_t   item;
    utf8s_pkg::out_item_t   head;
    utf8s_pkg::burst_stat_t stat;

    assign accept = s_tvalid && s_tready;

    // Holds the partial multibyte sequence and builds the burst for each request.
    utf8s_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .load       (load),
        .burst      (burst),
        .held_count (held_count)
    );

    // Walks through the stored burst, one byte per cycle while the queue has space.
    utf8s_burst u_burst
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .burst_in (burst),
        .space    (space),
        .in_ready (s_tready),
        .push     (push),
        .item     (item),
        .stat     (stat)
    );

    // Output queue; its fill level, not m_tready, decides whether the burst moves.
    utf8s_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata    = head.out_byte;
    assign m_tlast    = head.run_last;
    assign m_tuser[0] = head.text_end;

`ifndef SYNTH
    // End of text always leaves nothing held.
    a_fin_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (held_count == 2'd0))
        else $error("held sequence survives end of text");

    // End of text always causes at least one result.
    a_fin_gives_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> stat.active)
        else $error("end of text produced no burst");

    // The serializer index stays inside the stored burst.
    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stat.active |-> (utf8s_pkg::BURST_CW'(stat.rd) < stat.count))
        else $error("burst index beyond burst length");

    // The last byte of the text is also the last byte of its run.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("text end without run end");
`endif

endmodule

### tb/utf8_sanitize_checker.sv
`timescale 1ns / 100ps
// Checker for the UTF-8 sanitizer stream: predicts output bytes from accepted input
// requests and compares them with the output channel. Depends on utf8s_pkg.
module utf8_sanitize_checker
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // final_byte

    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic       m_tlast,   // run_last
    input  logic [0:0] m_tuser,   // [0] text_end

    output int         mismatch_count,
    output int         results_owed
);

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_BITS  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_BITS  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_BITS  = 8'hF0;
    localparam int         REPORT_MAX  = 10;

    // Predictor state: the partial sequence that is being held.
    logic [7:0] held_seq [0:2];
    logic [1:0] held_n;
    logic [2:0] seq_len;

    logic [7:0]           burst_bytes [$];
    utf8s_pkg::out_item_t expected_out [$];
    utf8s_pkg::out_item_t got;
    utf8s_pkg::out_item_t want;
    int                   errors;

    function void clear_hold();
        held_seq[0] = 8'h00;
        held_seq[1] = 8'h00;
        held_seq[2] = 8'h00;
        held_n      = 2'd0;
        seq_len     = 3'd0;
    endfunction

    function void add_byte(input logic [7:0] b);
        burst_bytes = {burst_bytes, b};
    endfunction

    function void push_repl();
        add_byte(utf8s_pkg::REPL_0);
        add_byte(utf8s_pkg::REPL_1);
        add_byte(utf8s_pkg::REPL_2);
    endfunction

    // Every held byte, lead or continuation, turns into one replacement character.
    function void flush_hold();
        for (int k = 0; k < held_n; k++)
            push_repl();
        clear_hold();
    endfunction

    function void hold_lead(input logic [7:0] b, input logic [2:0] len);
        held_seq[0] = b;
        held_n      = 2'd1;
        seq_len     = len;
    endfunction

    function void open_lead(input logic [7:0] b);
        if (b < ASCII_LIMIT)
            add_byte(b);
        else if ((b & LEAD2_MASK) == LEAD2_BITS)
            hold_lead(b, 3'd2);
        else if ((b & LEAD3_MASK) == LEAD3_BITS)
            hold_lead(b, 3'd3);
        else if ((b & LEAD4_MASK) == LEAD4_BITS)
            hold_lead(b, 3'd4);
        else
            push_repl();
    endfunction

    // Works out the output bytes of one input request and queues them.
    function void sanitize_byte(input logic [7:0] b, input logic fin);
        utf8s_pkg::out_item_t item;
        int                   n;
        burst_bytes.delete();
        if (held_n != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                if ({1'b0, held_n} + 3'd1 >= seq_len) begin
                    for (int j = 0; j < held_n; j++)
                        add_byte(held_seq[j]);
                    add_byte(b);
                    clear_hold();
                end
                else begin
                    held_seq[held_n] = b;
                    held_n           = held_n + 2'd1;
                end
            end
            else begin
                flush_hold();
                open_lead(b);
            end
        end
        else begin
            open_lead(b);
        end
        if (fin)
            flush_hold();
        n = burst_bytes.size();
        for (int k = 0; k < n; k++) begin
            item.out_byte = burst_bytes[k];
            item.run_last = (k == n - 1);
            item.text_end = (k == n - 1) && fin;
            expected_out = {expected_out, item};
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_hold();
            expected_out.delete();
            errors = 0;
            mismatch_count <= 0;
            results_owed   <= 0;
        end
        else begin
            // Outputs are checked before the new request is predicted; a result can
            // never belong to a request accepted at the same edge.
            if (m_tvalid && m_tready) begin
                got.out_byte = m_tdata;
                got.run_last = m_tlast;
                got.text_end = m_tuser[0];
                if (expected_out.size() == 0) begin
                    if (errors < REPORT_MAX)
                        $display("%0t: unexpected output byte %02h last %b end %b",
                                 $realtime, got.out_byte, got.run_last, got.text_end);
                    errors++;
                end
                else begin
                    want = expected_out.pop_front();
                    if (got.out_byte !== want.out_byte || got.run_last !== want.run_last
                        || got.text_end !== want.text_end) begin
                        if (errors < REPORT_MAX)
                            $display("%0t: expected byte %02h last %b end %b, got %02h %b %b",
                                     $realtime, want.out_byte, want.run_last, want.text_end,
                                     got.out_byte, got.run_last, got.text_end);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                sanitize_byte(s_tdata, s_tlast);
            mismatch_count <= errors;
            results_owed   <= expected_out.size();
        end
    end

endmodule

### tb/utf8_sanitize_stream_tb.sv
`timescale 1ns / 100ps
// Testbench top for the UTF-8 sanitizer stream: drives text bytes and output backpressure
// and gives the verdict. Depends on utf8_sanitize_stream and utf8_sanitize_checker.
module utf8_sanitize_stream_tb;

    // Longest stretch without any accepted request before the run is given up. The
    // slowest correct stretch is the long output hold-off plus one sender gap.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int RANDOM_ITEMS   = 240;
    localparam int DRAIN_CYCLES   = 16;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    int mismatch_count;
    int results_owed;
    int idle_cycles;
    int items_sent;

    // Set by the stimulus; the receiver picks them up at its next decision.
    bit quiet;
    bit long_hold_pending;

    utf8_sanitize_stream dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    utf8_sanitize_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // The watchdog counts cycles in which neither channel moves a request.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: random bursts of ready and not ready, one long hold-off on request,
    // and steady ready once the quiet tail of the run begins.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (quiet)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
    end

    // Offers one byte and returns at the edge where it is accepted. Outside the quiet
    // tail a random gap may come first. Called only at a rising edge, so the valid
    // stays high between back-to-back requests.
    task automatic send_req(input logic [7:0] b, input logic fin);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tdata  <= b;
        s_tlast  <= fin;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stops offering and waits until every predicted output byte has arrived. The first
    // edge lets the checker count the requests accepted at the current one.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        logic [31:0] r;
        r = $urandom;
        return {2'b10, r[5:0]};
    endfunction

    function automatic logic [7:0] lead_byte(input int len);
        logic [31:0] r;
        r = $urandom;
        if (len == 2)
            return {3'b110, r[4:0]};
        else if (len == 3)
            return {4'b1110, r[3:0]};
        else
            return {5'b11110, r[2:0]};
    endfunction

    // The end-of-text flag lands on random bytes, so it also cuts held sequences short.
    function automatic logic rand_fin();
        return ($urandom_range(0, 15) == 0);
    endfunction

    // One random piece of text. Most pieces are well-formed characters with random
    // payload; the rest are broken sequences, stray bytes and plain noise.
    task automatic send_chunk();
        int         kind;
        int         len;
        int         conts;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            send_req(8'($urandom_range(0, 127)), rand_fin());
        end
        else if (kind < 70)
        begin
            len = $urandom_range(2, 4);
            send_req(lead_byte(len), rand_fin());
            repeat (len - 1) send_req(cont_byte(), rand_fin());
        end
        else if (kind < 82)
        begin
            // A lead followed by too few continuations and then a byte that breaks it.
            len   = $urandom_range(2, 4);
            conts = $urandom_range(0, len - 2);
            send_req(lead_byte(len), rand_fin());
            repeat (conts) send_req(cont_byte(), rand_fin());
            do
                b = 8'($urandom_range(0, 255));
            while (b[7:6] == 2'b10);
            send_req(b, rand_fin());
        end
        else if (kind < 90)
        begin
            send_req(cont_byte(), rand_fin());
        end
        else if (kind < 95)
        begin
            send_req(8'($urandom_range(248, 255)), rand_fin());
        end
        else
        begin
            send_req(8'($urandom_range(0, 255)), rand_fin());
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        quiet    = 1'b0;
        long_hold_pending = 1'b0;
        items_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ASCII extremes, stray continuations and bytes that can never start a character.
        send_req(8'h00, 1'b0);
        send_req(8'h7F, 1'b0);
        send_req(8'h80, 1'b0);
        send_req(8'hBF, 1'b0);
        send_req(8'hF8, 1'b0);
        send_req(8'hFF, 1'b0);
        // Well-formed two, three and four byte characters.
        send_req(8'hC2, 1'b0);
        send_req(8'hA9, 1'b0);
        send_req(8'hE2, 1'b0);
        send_req(8'h82, 1'b0);
        send_req(8'hAC, 1'b0);
        send_req(8'hF0, 1'b0);
        send_req(8'h9F, 1'b0);
        send_req(8'h98, 1'b0);
        send_req(8'h80, 1'b0);
        // A sequence broken by ASCII, then one broken by a new lead that completes.
        send_req(8'hE2, 1'b0);
        send_req(8'h82, 1'b0);
        send_req(8'h41, 1'b0);
        send_req(8'hE2, 1'b0);
        send_req(8'hC3, 1'b0);
        send_req(8'hA9, 1'b0);
        // Three held bytes broken by an invalid byte at end of text: the largest burst.
        send_req(8'hF0, 1'b0);
        send_req(8'h9F, 1'b0);
        send_req(8'h98, 1'b0);
        send_req(8'hFF, 1'b1);
        // End of text on a plain byte, then on a lone held lead.
        send_req(8'h41, 1'b1);
        send_req(8'hC2, 1'b1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            send_chunk();
            // Long output hold-off while the sender keeps offering, so the block backs up.
            if (items_sent >= 90 && items_sent < 95)
                long_hold_pending = 1'b1;
            // Sender pauses until the output catches up, after chunks ending at 180 to 184.
            if (items_sent >= 180 && items_sent < 185)
                drain_outputs();
            if (items_sent >= RANDOM_ITEMS - 40)
                quiet = 1'b1;
        end
        long_hold_pending = 1'b0;
        send_req(8'h0A, 1'b1);

        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
